### design/lrp_pkg.sv
// Shared constants, register indexes, mode codes and divider handshake types
// for the level-to-RGB palette block. Depends on nothing; every other file
// imports it.
`timescale 1ns / 1ps

package lrp_pkg;

  localparam int LEVEL_W    = 18;
  localparam int COLOR_W    = 8;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = FRAC_W + 1;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_COMP   = 3;

  typedef logic [COLOR_W-1:0] color_t;

  // 1.0 in Q16.
  localparam logic [POS_W-1:0] Q_ONE = POS_W'(1) << FRAC_W;

  // Palette modes.
  localparam logic [MODE_W-1:0] MODE_SPECTRUM = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STRENGTH = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CYCLIC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SIMPLE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STATIC   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_SPEED = 3'd5;

  localparam color_t BASE_RESET  = 8'hFF;
  localparam color_t COLOR_FULL  = 8'hFF;
  localparam color_t FIXED_RED   = 8'hAA;
  localparam color_t FIXED_GREEN = 8'h88;
  localparam color_t FIXED_BLUE  = 8'h88;

  typedef struct packed {
    logic                   start;
    logic [2*COLOR_W-1:0]   dividend;
    logic [COLOR_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [COLOR_W-1:0]     quotient;
  } div_rsp_t;

endpackage

### design/lrp_if.sv
// Valid/ready channel interfaces for the level input, the color result and
// the configuration write port. Depends on lrp_pkg for the field widths.
`timescale 1ns / 1ps

interface lrp_in_if import lrp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface lrp_out_if import lrp_pkg::*; ();
  logic   valid;
  logic   ready;
  color_t red_out;
  color_t green_out;
  color_t blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                output ready);
endinterface

interface lrp_cfg_if import lrp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/lrp_divider.sv
// Bit-serial restoring divider: 16-bit dividend by 8-bit divisor, one
// quotient bit per cycle, for a quotient known to fit in 8 bits.
// Depends on lrp_pkg for the request and response types.
`timescale 1ns / 1ps

module lrp_divider import lrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [2:0] LAST_STEP = 3'(COLOR_W - 1);

  logic         busy_r;
  logic         done_r;
  logic [2:0]   cnt_r;
  color_t       rem_r;
  color_t       num_r;
  color_t       quo_r;
  color_t       divisor_r;

  logic [COLOR_W:0] trial;
  logic [COLOR_W:0] diff;
  logic             fits;

  // Partial remainder stays below the divisor, so the trial value is at most
  // nine bits and the sign of the difference decides the quotient bit.
  assign trial = {rem_r, num_r[COLOR_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign fits  = !diff[COLOR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r     <= req.dividend[2*COLOR_W-1:COLOR_W];
      num_r     <= req.dividend[COLOR_W-1:0];
      divisor_r <= req.divisor;
      quo_r     <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[COLOR_W-1:0] : trial[COLOR_W-1:0];
      num_r <= {num_r[COLOR_W-2:0], 1'b0};
      quo_r <= {quo_r[COLOR_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < divisor_r)
    else $error("divider remainder not below divisor");

  a_start_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r && !done_r)
    else $error("divider started while in use");

  a_done_after_last_step : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && ($past(cnt_r) == LAST_STEP))
    else $error("divider finished without a full run");

endmodule

### design/level_to_rgb_palette.sv
// Level-to-RGB palette: turns one Q16 level request into one 8-bit RGB color
// according to the mode register. Depends on lrp_pkg, lrp_if and lrp_divider.
//
// One level request is taken at a time and produces one color. Spectrum and
// cyclic modes brighten their colors with the bit-serial divider, and the
// three components go through it in turn; cyclic and simple modes add a
// bit-serial multiply that scales all three components at once by the level.
// Configuration writes are always taken and must only be issued while no
// request is in flight. A finished color waits in the output register while
// the next request is already taken.
`timescale 1ns / 1ps

module level_to_rgb_palette import lrp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  lrp_cfg_if.sink       cfg_chan,
  lrp_in_if.sink        in_chan,
  lrp_out_if.source     out_chan
);

  localparam logic [1:0] LAST_COMP = 2'(NUM_COMP - 1);
  localparam logic [2:0] LAST_BIT  = 3'(COLOR_W - 1);
  localparam int         PROD_W    = COLOR_W + FRAC_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HUE   = 7'b0000010,
    S_SEG   = 7'b0000100,
    S_MAX   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_SCALE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // floor(255 * f / 65536) for f in 0..65536.
  function automatic color_t rise(input logic [POS_W-1:0] f);
    logic [PROD_W:0] p;
    p = {f, {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, f};
    return p[PROD_W-1:FRAC_W];
  endfunction

  // 255 - ceil(255 * f / 65536) for f in 0..65536.
  function automatic color_t fall(input logic [POS_W-1:0] f);
    logic [PROD_W:0] p;
    p = {f, {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, f} + (PROD_W + 1)'(Q_ONE - 1);
    return COLOR_FULL - p[PROD_W-1:FRAC_W];
  endfunction

  // Configuration registers.
  logic [MODE_W-1:0] mode_r;
  color_t            base_red_r;
  color_t            base_green_r;
  color_t            base_blue_r;
  logic [FRAC_W-1:0] base_value_r;
  logic [FRAC_W-1:0] speed_r;

  // Control state.
  state_t            state_r, state_nxt;
  logic [FRAC_W-1:0] phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              div_wait_r, div_wait_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [2:0]        cnt_r, cnt_nxt;

  // Item payload.
  logic [POS_W-1:0]  v_r, v_nxt;
  logic [POS_W-1:0]  x_r, x_nxt;
  logic              bright_r, bright_nxt;
  logic              scale_r, scale_nxt;
  color_t            max_r, max_nxt;
  color_t            col_r [NUM_COMP];
  color_t            col_nxt [NUM_COMP];
  logic [PROD_W-1:0] prod_r [NUM_COMP];
  logic [PROD_W-1:0] prod_nxt [NUM_COMP];
  color_t            out_red_r, out_red_nxt;
  color_t            out_green_r, out_green_nxt;
  color_t            out_blue_r, out_blue_nxt;

  logic              in_fire;
  logic [POS_W-1:0]  lvl_mag;
  logic [POS_W-1:0]  lvl_clamp;
  logic [POS_W-1:0]  hue_sum;
  logic [POS_W-1:0]  hue_pos;
  logic [POS_W:0]    spec_t;
  logic [POS_W-1:0]  spec_f;
  color_t            spec_up;
  color_t            spec_dn;
  logic [POS_W+1:0]  str_s;
  logic [2:0]        str_k;
  logic [POS_W-1:0]  str_f;
  color_t            str_x;
  color_t            max01;
  color_t            max012;
  logic              out_load;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_SPECTRUM;
      base_red_r   <= BASE_RESET;
      base_green_r <= BASE_RESET;
      base_blue_r  <= BASE_RESET;
      base_value_r <= '0;
      speed_r      <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_MODE:        mode_r       <= cfg_chan.data[MODE_W-1:0];
        REG_BASE_RED:    base_red_r   <= cfg_chan.data[COLOR_W-1:0];
        REG_BASE_GREEN:  base_green_r <= cfg_chan.data[COLOR_W-1:0];
        REG_BASE_BLUE:   base_blue_r  <= cfg_chan.data[COLOR_W-1:0];
        REG_BASE_VALUE:  base_value_r <= cfg_chan.data[FRAC_W-1:0];
        REG_CYCLE_SPEED: speed_r      <= cfg_chan.data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Negative levels clamp to zero, levels above 1.0 clamp to 1.0.
  assign lvl_mag   = in_chan.level[POS_W-1:0];
  assign lvl_clamp = in_chan.level[LEVEL_W-1] ? '0 :
                     (lvl_mag > Q_ONE) ? Q_ONE : lvl_mag;

  // The hue sum only wraps when it passes 1.0, so exactly 1.0 stays as is.
  assign hue_sum = {1'b0, base_value_r} + {1'b0, phase_r};
  assign hue_pos = (hue_sum > Q_ONE) ? {1'b0, hue_sum[FRAC_W-1:0]} : hue_sum;

  // Spectrum: three segments of t = 3x; the top segment reaches f = 1.0.
  assign spec_t  = {x_r, 1'b0} + {1'b0, x_r};
  assign spec_f  = spec_t[POS_W] ? spec_t[POS_W-1:0] : {1'b0, spec_t[FRAC_W-1:0]};
  assign spec_up = rise(spec_f);
  assign spec_dn = fall(spec_f);

  // Strength: five segments of s = 5x; level 1.0 stays in the last segment.
  assign str_s = {x_r, 2'b00} + {2'b00, x_r};
  assign str_k = str_s[POS_W+1:FRAC_W];
  assign str_f = (str_k > 3'd4) ? Q_ONE : {1'b0, str_s[FRAC_W-1:0]};
  assign str_x = rise(str_f);

  assign max01  = (col_r[0] > col_r[1]) ? col_r[0] : col_r[1];
  assign max012 = (col_r[2] > max01) ? col_r[2] : max01;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  assign div_req.start    = (state_r == S_DIV) && !div_wait_r;
  assign div_req.dividend = {col_r[idx_r], {COLOR_W{1'b0}}} - {{COLOR_W{1'b0}}, col_r[idx_r]};
  assign div_req.divisor  = max_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    div_wait_nxt  = div_wait_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    v_nxt         = v_r;
    x_nxt         = x_r;
    bright_nxt    = bright_r;
    scale_nxt     = scale_r;
    max_nxt       = max_r;
    col_nxt       = col_r;
    prod_nxt      = prod_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          v_nxt = lvl_clamp;
          x_nxt = lvl_clamp;
          if (mode_r == MODE_CYCLIC) begin
            phase_nxt = phase_r + speed_r;
          end
          state_nxt = S_HUE;
        end
      end
      S_HUE: begin
        if (mode_r == MODE_CYCLIC) begin
          x_nxt = hue_pos;
        end
        state_nxt = S_SEG;
      end
      S_SEG: begin
        bright_nxt = 1'b0;
        scale_nxt  = 1'b0;
        case (mode_r)
          MODE_SPECTRUM, MODE_CYCLIC: begin
            if (spec_t[POS_W]) begin
              col_nxt[0] = spec_up; col_nxt[1] = spec_dn; col_nxt[2] = '0;
            end else if (spec_t[FRAC_W]) begin
              col_nxt[0] = '0; col_nxt[1] = spec_up; col_nxt[2] = spec_dn;
            end else begin
              col_nxt[0] = spec_dn; col_nxt[1] = '0; col_nxt[2] = spec_up;
            end
            bright_nxt = 1'b1;
            scale_nxt  = (mode_r == MODE_CYCLIC);
          end
          MODE_STRENGTH: begin
            // Every segment above the first holds a full component, so brightening
            // would leave it unchanged; strength mode brightens no segment at all.
            case (str_k)
              3'd0: begin
                col_nxt[0] = '0; col_nxt[1] = '0; col_nxt[2] = str_x;
              end
              3'd1: begin
                col_nxt[0] = str_x; col_nxt[1] = '0; col_nxt[2] = COLOR_FULL;
              end
              3'd2: begin
                col_nxt[0] = COLOR_FULL; col_nxt[1] = '0; col_nxt[2] = str_x;
              end
              3'd3: begin
                col_nxt[0] = COLOR_FULL; col_nxt[1] = str_x; col_nxt[2] = '0;
              end
              default: begin
                col_nxt[0] = COLOR_FULL; col_nxt[1] = COLOR_FULL; col_nxt[2] = str_x;
              end
            endcase
          end
          MODE_SIMPLE, MODE_STATIC: begin
            col_nxt[0] = base_red_r;
            col_nxt[1] = base_green_r;
            col_nxt[2] = base_blue_r;
            scale_nxt  = (mode_r == MODE_SIMPLE);
          end
          default: begin
            col_nxt[0] = FIXED_RED;
            col_nxt[1] = FIXED_GREEN;
            col_nxt[2] = FIXED_BLUE;
          end
        endcase
        state_nxt = S_MAX;
      end
      S_MAX: begin
        max_nxt = max012;
        idx_nxt = '0;
        cnt_nxt = '0;
        for (int k = 0; k < NUM_COMP; k++) begin
          prod_nxt[k] = '0;
        end
        if (bright_r && (max012 != '0)) begin
          state_nxt = S_DIV;
        end else if (scale_r) begin
          state_nxt = S_SCALE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (div_req.start) begin
          div_wait_nxt = 1'b1;
        end else if (div_rsp.done) begin
          div_wait_nxt   = 1'b0;
          col_nxt[idx_r] = div_rsp.quotient;
          if (idx_r == LAST_COMP) begin
            state_nxt = scale_r ? S_SCALE : S_OUT;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      S_SCALE: begin
        // Multiply by the level, component bits taken most significant first.
        for (int k = 0; k < NUM_COMP; k++) begin
          prod_nxt[k] = {prod_r[k][PROD_W-2:0], 1'b0} +
                        (col_r[k][COLOR_W-1] ? {{(PROD_W-POS_W){1'b0}}, v_r} : '0);
          col_nxt[k]  = (cnt_r == LAST_BIT) ? prod_nxt[k][PROD_W-1:FRAC_W] :
                                              {col_r[k][COLOR_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == LAST_BIT) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_red_nxt   = col_r[0];
          out_green_nxt = col_r[1];
          out_blue_nxt  = col_r[2];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      div_wait_r  <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      div_wait_r  <= div_wait_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    x_r         <= x_nxt;
    bright_r    <= bright_nxt;
    scale_r     <= scale_nxt;
    max_r       <= max_nxt;
    col_r       <= col_nxt;
    prod_r      <= prod_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  lrp_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_chan.valid     = out_valid_r;
  assign out_chan.red_out   = out_red_r;
  assign out_chan.green_out = out_green_r;
  assign out_chan.blue_out  = out_blue_r;

  a_div_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (max_r != '0))
    else $error("brightening with a zero maximum");

  a_phase_only_cyclic : assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire || (mode_r != MODE_CYCLIC)) |=> $stable(phase_r))
    else $error("phase moved outside a cyclic request");

  a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished color not presented");

  a_div_done_expected : assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV) && div_wait_r)
    else $error("unexpected divider result");

endmodule
